@@ hdl/polygon_area_perimeter_assert.svh @@
// Assertion macros used by the polygon area and perimeter checker.
`ifndef POLYGON_AREA_PERIMETER_ASSERT_SVH
`define POLYGON_AREA_PERIMETER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define PAP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("polygon_area_perimeter: assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define PAP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("polygon_area_perimeter: assertion failed");

`endif

@@ hdl/pap_pkg.sv @@
// Package with the payload types and constants of the polygon area and perimeter block.
package pap_pkg;

	localparam int VX_BITS         = 24;
	localparam int AREA_BITS       = 63;
	localparam int PERIM_BITS      = 63;
	localparam int TOTAL_BITS      = 16;
	localparam int SUM_BITS        = 64;

	localparam int DEF_COORD_BITS  = 24;
	localparam int DEF_COUNT_BITS  = 16;
	localparam int DEF_FRAC_BITS   = 4;

	typedef struct packed {
		logic signed [VX_BITS-1:0] vx;
		logic signed [VX_BITS-1:0] vy;
		logic                      last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [AREA_BITS-1:0]  twice_area;
		logic [PERIM_BITS-1:0] perimeter_fixed;
		logic [TOTAL_BITS-1:0] vertex_total;
		logic                  shape_valid;
	} result_t;

endpackage

@@ hdl/polygon_area_perimeter.sv @@
// Top level of the shoelace polygon area and perimeter block.
// This block takes the vertices of one closed polygon, one request per vertex, with
// last_vertex set on the final one, and returns one result request per polygon: twice
// the absolute shoelace area, the perimeter with FRAC_BITS fraction bits, the vertex
// count and a flag that is set for three or more vertices with nonzero area. A polygon
// with fewer than three vertices reports zero area and zero perimeter. Coordinates use
// the low COORD_BITS bits of vx and vy, sign-extended. The area and perimeter sums and
// the vertex count saturate. The first vertex of a polygon only records its coordinates.
// Every later vertex adds one edge, and the block takes no further vertex until that
// edge is done: four products on one shared signed multiplier for the cross product
// and the squared deltas, a step to form the radicand, COORD_BITS + FRAC_BITS + 1
// steps of a shared two-bits-per-step square root, and a step to add the edge length.
// The final vertex runs that sequence twice, the second time for the edge that closes
// the polygon, and then hands the result to the output register, which may hold it
// while the next polygon is already being received.
module polygon_area_perimeter
	import pap_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    vertex_valid,
	output logic    vertex_ready,
	input  vertex_t vertex,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// Derived widths. A product of two deltas needs 2*COORD_BITS+2 bits signed, a shoelace
	// term 2*COORD_BITS+1 bits signed, and the sum of two squares 2*COORD_BITS+1 bits.
	localparam int DW         = COORD_BITS + 1;
	localparam int MUL_W      = 2 * COORD_BITS + 2;
	localparam int TERM_W     = 2 * COORD_BITS + 1;
	localparam int SUMSQ_W    = 2 * COORD_BITS + 1;
	localparam int SQ_BITS    = SUMSQ_W + 2 * FRAC_BITS;
	localparam int ROOT_BITS  = (SQ_BITS + 1) / 2;

	localparam logic signed [SUM_BITS:0] CROSS_MAX = {2'b00, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS:0] CROSS_MIN = -CROSS_MAX;
	localparam logic [SQ_BITS-1:0]       BIT_START = {1'b1, {(SQ_BITS-1){1'b0}}};
	localparam logic [SQ_BITS-1:0]       BIT_LAST  = {{(SQ_BITS-1){1'b0}}, 1'b1};
	localparam logic [COUNT_BITS-1:0]    COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0]    COUNT_MIN_SHAPE = COUNT_BITS'(3);

	// Sequencer state codes.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M0   = 4'd1;
	localparam logic [3:0] ST_M1   = 4'd2;
	localparam logic [3:0] ST_M2   = 4'd3;
	localparam logic [3:0] ST_M3   = 4'd4;
	localparam logic [3:0] ST_M4   = 4'd5;
	localparam logic [3:0] ST_SQRT = 4'd6;
	localparam logic [3:0] ST_LEN  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]                  state_q;
	logic [COUNT_BITS-1:0]       count_q;
	logic                        last_q;
	logic                        close_q;
	logic                        result_valid_q;
	logic signed [SUM_BITS-1:0]  cross_q;
	logic [PERIM_BITS-1:0]       length_q;

	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] ea_x_q, ea_y_q, eb_x_q, eb_y_q;
	logic signed [DW-1:0]         dx_q, dy_q;
	logic signed [MUL_W-1:0]      mul_q;
	logic signed [TERM_W-1:0]     term_q;
	logic [SUMSQ_W-1:0]           sq_q;
	logic [SQ_BITS-1:0]           n_q, res_q, bit_q;
	result_t                      result_q;

	logic signed [COORD_BITS-1:0] in_x, in_y;
	logic                         accept;
	logic                         out_free;
	logic signed [DW-1:0]         mul_a, mul_b;
	logic [SUMSQ_W-1:0]           sq_total;
	logic [SQ_BITS:0]             trial;
	logic                         take;
	logic signed [SUM_BITS:0]     cross_wide;
	logic [SUM_BITS-1:0]          length_wide;
	logic [SUM_BITS-1:0]          cross_abs;
	logic                         few;
	result_t                      result_d;

	assign in_x     = vertex.vx[COORD_BITS-1:0];
	assign in_y     = vertex.vy[COORD_BITS-1:0];
	assign vertex_ready = (state_q == ST_IDLE);
	assign accept   = vertex_valid && vertex_ready;
	assign out_free = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result   = result_q;

	// The one multiplier is shared by both cross products and both squared deltas.
	always_comb begin
		unique case (state_q)
			ST_M0: begin
				mul_a = {ea_x_q[COORD_BITS-1], ea_x_q};
				mul_b = {eb_y_q[COORD_BITS-1], eb_y_q};
			end
			ST_M1: begin
				mul_a = {eb_x_q[COORD_BITS-1], eb_x_q};
				mul_b = {ea_y_q[COORD_BITS-1], ea_y_q};
			end
			ST_M2: begin
				mul_a = dx_q;
				mul_b = dx_q;
			end
			ST_M3: begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Squares are never negative and stay below 2^(2*COORD_BITS).
	assign sq_total = sq_q + SUMSQ_W'(mul_q[2*COORD_BITS-1:0]);

	// One step of the digit-by-digit square root.
	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = ({1'b0, n_q} >= trial);

	// Saturating accumulators. The cross sum stays within plus and minus 2^63-1.
	assign cross_wide  = $signed({cross_q[SUM_BITS-1], cross_q}) + (SUM_BITS+1)'(term_q);
	assign length_wide = {1'b0, length_q} + SUM_BITS'(res_q[ROOT_BITS-1:0]);

	// Result fields. Fewer than three vertices report zero area and perimeter.
	assign cross_abs = cross_q[SUM_BITS-1] ? SUM_BITS'(-cross_q) : SUM_BITS'(cross_q);
	assign few       = (count_q < COUNT_MIN_SHAPE);

	always_comb begin
		result_d.twice_area      = few ? '0 : cross_abs[AREA_BITS-1:0];
		result_d.perimeter_fixed = few ? '0 : length_q;
		result_d.vertex_total    = TOTAL_BITS'(count_q);
		result_d.shape_valid     = !few && (cross_abs[AREA_BITS-1:0] != '0);
	end

	// Control state and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			last_q         <= 1'b0;
			close_q        <= 1'b0;
			result_valid_q <= 1'b0;
			cross_q        <= '0;
			length_q       <= '0;
		end else begin
			// The output register fills when a finished polygon finds it free, and it
			// stays full until the receiver takes the request.
			result_valid_q <= (state_q == ST_DONE && out_free) ||
				(result_valid_q && !result_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_BITS'(1);
						end
						last_q <= vertex.last_vertex;
						if (count_q == '0) begin
							close_q <= 1'b0;
							state_q <= vertex.last_vertex ? ST_DONE : ST_IDLE;
						end else begin
							// The closing edge follows the edge from the previous vertex.
							close_q <= vertex.last_vertex;
							state_q <= ST_M0;
						end
					end
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: begin
					if (cross_wide > CROSS_MAX) begin
						cross_q <= SUM_BITS'(CROSS_MAX);
					end else if (cross_wide < CROSS_MIN) begin
						cross_q <= SUM_BITS'(CROSS_MIN);
					end else begin
						cross_q <= SUM_BITS'(cross_wide);
					end
					state_q <= ST_M4;
				end
				ST_M4: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (bit_q == BIT_LAST) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (length_wide[SUM_BITS-1]) begin
						length_q <= '1;
					end else begin
						length_q <= length_wide[PERIM_BITS-1:0];
					end
					if (close_q) begin
						close_q <= 1'b0;
						state_q <= ST_M0;
					end else if (last_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						count_q        <= '0;
						cross_q        <= '0;
						length_q       <= '0;
						last_q         <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (count_q == '0) begin
						first_x_q <= in_x;
						first_y_q <= in_y;
					end
					ea_x_q   <= prev_x_q;
					ea_y_q   <= prev_y_q;
					eb_x_q   <= in_x;
					eb_y_q   <= in_y;
					prev_x_q <= in_x;
					prev_y_q <= in_y;
				end
			end
			ST_M0: begin
				mul_q <= mul_a * mul_b;
				dx_q  <= {eb_x_q[COORD_BITS-1], eb_x_q} - {ea_x_q[COORD_BITS-1], ea_x_q};
				dy_q  <= {eb_y_q[COORD_BITS-1], eb_y_q} - {ea_y_q[COORD_BITS-1], ea_y_q};
			end
			ST_M1: begin
				mul_q  <= mul_a * mul_b;
				term_q <= TERM_W'(mul_q);
			end
			ST_M2: begin
				mul_q  <= mul_a * mul_b;
				term_q <= term_q - TERM_W'(mul_q);
			end
			ST_M3: begin
				mul_q <= mul_a * mul_b;
				sq_q  <= SUMSQ_W'(mul_q[2*COORD_BITS-1:0]);
			end
			ST_M4: begin
				n_q   <= SQ_BITS'(sq_total) << (2 * FRAC_BITS);
				res_q <= '0;
				bit_q <= BIT_START;
			end
			ST_SQRT: begin
				if (take) begin
					n_q   <= n_q - trial[SQ_BITS-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_LEN: begin
				if (close_q) begin
					ea_x_q <= prev_x_q;
					ea_y_q <= prev_y_q;
					eb_x_q <= first_x_q;
					eb_y_q <= first_y_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					result_q <= result_d;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/pap_checker.sv @@
// Port-level checker for the polygon area and perimeter block, with its bind.
`include "polygon_area_perimeter_assert.svh"

module pap_checker
	import pap_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    vertex_valid,
	input logic    vertex_ready,
	input vertex_t vertex,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	logic last_taken;
	logic result_wait;
	logic shape_result;
	logic shape_fields_ok;
	logic short_result;
	logic short_fields_zero;

	assign last_taken        = vertex_valid && vertex_ready && vertex.last_vertex;
	assign result_wait       = result_valid && !result_ready;
	assign shape_result      = result_valid && result.shape_valid;
	assign shape_fields_ok   = (result.vertex_total >= TOTAL_BITS'(3)) &&
		(result.twice_area != '0);
	assign short_result      = result_valid && (result.vertex_total < TOTAL_BITS'(3));
	assign short_fields_zero = (result.twice_area == '0) && (result.perimeter_fixed == '0) &&
		(result.vertex_total != '0);

	// A waiting result holds its payload until it is taken.
	`PAP_ASSERT_NEXT(a_result_hold, result_wait, result_valid && $stable(result))

	// After the final vertex of a polygon is taken the block is busy closing it.
	`PAP_ASSERT_NEXT(a_busy_after_last, last_taken, !vertex_ready)

	// A valid shape has at least three vertices and nonzero area.
	`PAP_ASSERT_NOW(a_shape_rule, shape_result, shape_fields_ok)

	// Short polygons report no area, no perimeter, and at least one vertex.
	`PAP_ASSERT_NOW(a_short_zero, short_result, short_fields_zero)

endmodule

bind polygon_area_perimeter pap_checker u_pap_checker (.*);
